FILE: design/sfd_pkg.sv
// sfd_pkg: shared constants and register codes for the stereo feedback delay.
// No dependencies; imported by sfd_dmod and stereo_feedback_delay_top.
`default_nettype none

package sfd_pkg;

  localparam int DELAY_W   = 17;  // delay register width
  localparam int GAIN_W    = 15;  // unsigned Q0.15 gain width
  localparam int GAIN_FRAC = 15;  // fractional bits of the gain
  localparam int REG_IDX_W = 2;

  localparam logic [DELAY_W-1:0] LEFT_DELAY_RST  = 17'd9600;
  localparam logic [DELAY_W-1:0] RIGHT_DELAY_RST = 17'd14400;
  localparam logic [GAIN_W-1:0]  LEFT_GAIN_RST   = 15'd19661;
  localparam logic [GAIN_W-1:0]  RIGHT_GAIN_RST  = 15'd16384;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEFT_DELAY  = 2'd0,
    REG_RIGHT_DELAY = 2'd1,
    REG_LEFT_GAIN   = 2'd2,
    REG_RIGHT_GAIN  = 2'd3
  } sfd_reg_t;

endpackage

`default_nettype wire

FILE: design/stereo_feedback_delay_top.sv
// stereo_feedback_delay_top: mono in, stereo echo out, one delay RAM per channel.
// Depends on sfd_pkg, sfd_ram, sfd_dmod.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_dry_sample
//   out      output     out_valid / out_ready  out_left_sample, out_right_sample
//   cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// No beat is taken while another is in stage 1: its feedback write-back must
// land (or be forwarded) before the next beat reads the delay RAMs. out_valid
// rises once a beat has passed stage 1, stage 2 and the output register.
// After reset and after a delay write, in_ready stays low while the
// delay is reduced modulo the store depth. No clearing pass: a fill tracker
// reads never-written entries as zero. A stalled output holds the last stage.
`default_nettype none

module stereo_feedback_delay_top import sfd_pkg::*; #(
  parameter int STORE_DEPTH = 131072,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_dry_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [SAMPLE_BITS-1:0] out_left_sample,
  output logic signed      [SAMPLE_BITS-1:0] out_right_sample,
  input  wire logic                          cfg_we,
  input  wire logic        [REG_IDX_W-1:0]   cfg_index,
  input  wire logic        [DELAY_W-1:0]     cfg_wdata
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = GAIN_W + 1 + SB;   // product width
  localparam int SW = SB + 2;            // feedback sum width
  localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (SB - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [PW-1:0] RND    = PW'(1) << (GAIN_FRAC - 1);

  // configuration
  logic [GAIN_W-1:0] left_gain_r, right_gain_r;
  logic [AW-1:0]     l_dmod, r_dmod;
  logic              l_busy, r_busy;

  // write position and fill tracking
  logic [AW-1:0] wp_r;
  logic          wrapped_r;

  // stage 1: RAM data arrives
  logic                 s1_valid_r, s1_lvld_r, s1_rvld_r, s1_lfwd_r, s1_rfwd_r;
  logic signed [SB-1:0] s1_dry_r;
  logic [AW-1:0]        s1_wp_r;

  // stage 2: round, saturate, write back, mix
  logic                 s2_valid_r;
  logic signed [SB-1:0] s2_dry_r, s2_lwet_r, s2_rwet_r;
  logic [AW-1:0]        s2_wp_r;
  logic signed [PW-1:0] s2_lprod_r, s2_rprod_r;

  logic signed [SB-1:0] fwd_l_r, fwd_r_r;
  logic                 out_valid_r;

  logic                 accept, s2_done;
  logic [AW:0]          l_rd_ext, r_rd_ext;
  logic [AW-1:0]        l_rd, r_rd;
  logic                 l_vld, r_vld, l_fwd, r_fwd;
  logic [SB-1:0]        l_rdata, r_rdata;
  logic signed [SB-1:0] l_wet, r_wet;
  logic signed [PW-1:0] l_prod, r_prod, l_rnd, r_rnd, l_fb, r_fb;
  logic signed [SW-1:0] l_sum, r_sum;
  logic signed [SB-1:0] l_wdata, r_wdata;
  logic signed [SB:0]   l_mix, r_mix;

  sfd_dmod #(.STORE_DEPTH(STORE_DEPTH), .RESET_VALUE(LEFT_DELAY_RST)) u_ldmod (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_we && (cfg_index == REG_LEFT_DELAY)),
    .wr_data   (cfg_wdata),
    .busy      (l_busy),
    .delay_mod (l_dmod)
  );

  sfd_dmod #(.STORE_DEPTH(STORE_DEPTH), .RESET_VALUE(RIGHT_DELAY_RST)) u_rdmod (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_we && (cfg_index == REG_RIGHT_DELAY)),
    .wr_data   (cfg_wdata),
    .busy      (r_busy),
    .delay_mod (r_dmod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_gain_r  <= LEFT_GAIN_RST;
      right_gain_r <= RIGHT_GAIN_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_LEFT_GAIN) begin
        left_gain_r <= cfg_wdata[GAIN_W-1:0];
      end
      if (cfg_index == REG_RIGHT_GAIN) begin
        right_gain_r <= cfg_wdata[GAIN_W-1:0];
      end
    end
  end

  assign s2_done  = s2_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r && (!s2_valid_r || s2_done) && !l_busy && !r_busy;
  assign accept   = in_valid && in_ready;

  // read addresses: (wp - delay) mod depth, delay already reduced below depth
  always_comb begin
    l_rd_ext = ({1'b0, wp_r} >= {1'b0, l_dmod}) ? {1'b0, wp_r} - {1'b0, l_dmod}
             : {1'b0, wp_r} + (AW+1)'(STORE_DEPTH) - {1'b0, l_dmod};
    r_rd_ext = ({1'b0, wp_r} >= {1'b0, r_dmod}) ? {1'b0, wp_r} - {1'b0, r_dmod}
             : {1'b0, wp_r} + (AW+1)'(STORE_DEPTH) - {1'b0, r_dmod};
    l_rd  = l_rd_ext[AW-1:0];
    r_rd  = r_rd_ext[AW-1:0];
    // entries below wp were written since reset; all of them once wrapped
    l_vld = wrapped_r || (l_rd < wp_r);
    r_vld = wrapped_r || (r_rd < wp_r);
    // stage 2 writes on this same edge, so the RAM would return stale data
    l_fwd = s2_valid_r && (l_rd == s2_wp_r);
    r_fwd = s2_valid_r && (r_rd == s2_wp_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (accept) begin
      if (wp_r == AW'(STORE_DEPTH - 1)) begin
        wp_r      <= '0;
        wrapped_r <= 1'b1;
      end else begin
        wp_r <= wp_r + 1'b1;
      end
    end
  end

  sfd_ram #(.WIDTH(SB), .DEPTH(STORE_DEPTH)) u_lram (
    .clk   (clk),
    .we    (s2_done),
    .waddr (s2_wp_r),
    .wdata (l_wdata),
    .re    (accept),
    .raddr (l_rd),
    .rdata (l_rdata)
  );

  sfd_ram #(.WIDTH(SB), .DEPTH(STORE_DEPTH)) u_rram (
    .clk   (clk),
    .we    (s2_done),
    .waddr (s2_wp_r),
    .wdata (r_wdata),
    .re    (accept),
    .raddr (r_rd),
    .rdata (r_rdata)
  );

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dry_r  <= in_dry_sample;
      s1_wp_r   <= wp_r;
      s1_lvld_r <= l_vld;
      s1_rvld_r <= r_vld;
      s1_lfwd_r <= l_fwd;
      s1_rfwd_r <= r_fwd;
    end
  end

  always_comb begin
    l_wet  = s1_lfwd_r ? fwd_l_r : (s1_lvld_r ? $signed(l_rdata) : '0);
    r_wet  = s1_rfwd_r ? fwd_r_r : (s1_rvld_r ? $signed(r_rdata) : '0);
    l_prod = $signed({1'b0, left_gain_r}) * l_wet;
    r_prod = $signed({1'b0, right_gain_r}) * r_wet;
  end

  // stage 2; stage 1 always advances since it is only filled into a free stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_valid_r) begin
      s2_valid_r <= 1'b1;
    end else if (s2_done) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_dry_r   <= s1_dry_r;
      s2_wp_r    <= s1_wp_r;
      s2_lwet_r  <= l_wet;
      s2_rwet_r  <= r_wet;
      s2_lprod_r <= l_prod;
      s2_rprod_r <= r_prod;
    end
  end

  always_comb begin
    l_rnd = s2_lprod_r + RND;
    r_rnd = s2_rprod_r + RND;
    l_fb  = l_rnd >>> GAIN_FRAC;
    r_fb  = r_rnd >>> GAIN_FRAC;
    l_sum = SW'(s2_dry_r) + SW'(l_fb);
    r_sum = SW'(s2_dry_r) + SW'(r_fb);
    if (l_sum > SAT_HI) begin
      l_wdata = SAT_HI[SB-1:0];
    end else if (l_sum < SAT_LO) begin
      l_wdata = SAT_LO[SB-1:0];
    end else begin
      l_wdata = l_sum[SB-1:0];
    end
    if (r_sum > SAT_HI) begin
      r_wdata = SAT_HI[SB-1:0];
    end else if (r_sum < SAT_LO) begin
      r_wdata = SAT_LO[SB-1:0];
    end else begin
      r_wdata = r_sum[SB-1:0];
    end
    // floor((dry + wet) / 2)
    l_mix = (SB+1)'(s2_dry_r) + (SB+1)'(s2_lwet_r);
    r_mix = (SB+1)'(s2_dry_r) + (SB+1)'(s2_rwet_r);
  end

  always_ff @(posedge clk) begin
    if (s2_done) begin
      fwd_l_r          <= l_wdata;
      fwd_r_r          <= r_wdata;
      out_left_sample  <= l_mix[SB:1];
      out_right_sample <= r_mix[SB:1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> s2_valid_r)
    else $error("stage 1 beat did not move to stage 2");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_done) |=> s2_valid_r && $stable(s2_wp_r))
    else $error("stalled stage 2 beat lost");

  a_wp_moves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (wp_r != $past(wp_r)))
    else $error("write position did not advance on accepted beat");

  a_wrapped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("fill tracker cleared outside reset");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (l_busy || r_busy) |-> !s1_valid_r || !$past(l_busy || r_busy))
    else $error("beat in flight during delay reduction");
`endif

endmodule

`default_nettype wire

FILE: design/sfd_ram.sv
// sfd_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none

module sfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/sfd_dmod.sv
// sfd_dmod: delay register reduced modulo the store depth by a reciprocal multiply.
// Depends on sfd_pkg. After a write the quotient is registered first, then the remainder.
`default_nettype none

module sfd_dmod import sfd_pkg::*; #(
  parameter int                 STORE_DEPTH = 131072,
  parameter logic [DELAY_W-1:0] RESET_VALUE = '0
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [DELAY_W-1:0]             wr_data,
  output logic                                busy,
  output logic      [$clog2(STORE_DEPTH)-1:0] delay_mod
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int RW = DELAY_W + 2;        // reciprocal width
  localparam int PW = DELAY_W + RW;       // product width
  localparam int SH = DELAY_W + AW;       // reciprocal scale
  // ceil(2^SH / depth) gives the exact quotient for every DELAY_W-bit value
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH);
  localparam logic [RW-1:0]      RECIP    = RW'(RECIP_L);
  localparam logic [DELAY_W-1:0] DEPTH_LO = DELAY_W'(STORE_DEPTH);

  logic [DELAY_W-1:0] del_r, del_nxt;
  logic [DELAY_W-1:0] quo_r, quo_nxt;
  logic [DELAY_W-1:0] rem_r, rem_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [PW-1:0]      prod;

  always_comb begin
    prod    = PW'(del_r) * PW'(RECIP);
    quo_nxt = DELAY_W'(prod >> SH);
    // true remainder is below 2^DELAY_W, so low bits of q * depth are enough
    rem_nxt = del_r - quo_r * DEPTH_LO;
    del_nxt = del_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      del_nxt = wr_data;
      cnt_nxt = 2'd2;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      del_r <= RESET_VALUE;
      quo_r <= '0;
      rem_r <= '0;
      cnt_r <= 2'd2;
    end else begin
      del_r <= del_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign busy      = (cnt_r != '0);
  assign delay_mod = AW'(rem_r);

endmodule

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking testbench for stereo_feedback_delay_top (mono in, stereo echo out).
// Depends on sfd_pkg and the design sources. A cycle-free model of both delay taps
// predicts every output beat. Stimulus is directed cases first, then randomized phases.
module tb;
  import sfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS = 16;
  localparam int STORE_DEPTH = 1 << DELAY_W;
  localparam int SAMPLE_MAX  = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAMPLE_MIN  = -(1 << (SAMPLE_BITS - 1));
  localparam int GAIN_MAX    = (1 << GAIN_W) - 1;
  localparam int DELAY_MAX   = STORE_DEPTH - 1;
  localparam int TIMEOUT_NS  = 3_000_000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t left;
    sample_t right;
  } echo_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_dry_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t out_left_sample;
  sample_t out_right_sample;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [DELAY_W-1:0] cfg_wdata = '0;

  // echo model state: channel 0 is left, channel 1 is right
  sample_t            tap_mem [2][STORE_DEPTH];
  logic [DELAY_W-1:0] tap_delay [2];
  logic [GAIN_W-1:0]  tap_gain [2];
  logic [DELAY_W-1:0] wr_pos;

  echo_pair_t echo_q[$];

  bit idle_on = 1'b1;
  int fail_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int settings_used = 0;

  stereo_feedback_delay_top #(
    .STORE_DEPTH(STORE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_dry_sample   (in_dry_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_sample (out_left_sample),
    .out_right_sample(out_right_sample),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void reset_echo_model();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      tap_mem[0][i] = '0;
      tap_mem[1][i] = '0;
    end
    tap_delay[0] = LEFT_DELAY_RST;
    tap_delay[1] = RIGHT_DELAY_RST;
    tap_gain[0]  = LEFT_GAIN_RST;
    tap_gain[1]  = RIGHT_GAIN_RST;
    wr_pos = '0;
  endfunction

  // one sample through both taps; read before write, so a zero delay sees the oldest entry
  function automatic echo_pair_t step_echo(sample_t dry);
    echo_pair_t res;
    logic [DELAY_W-1:0] rd;
    int wet;
    int fb;
    int sum;
    int mixed;
    for (int ch = 0; ch < 2; ch++) begin
      rd = wr_pos - tap_delay[ch];
      wet = tap_mem[ch][rd];
      fb = (int'(tap_gain[ch]) * wet + (1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
      sum = int'(dry) + fb;
      if (sum > SAMPLE_MAX) sum = SAMPLE_MAX;
      if (sum < SAMPLE_MIN) sum = SAMPLE_MIN;
      tap_mem[ch][wr_pos] = sum[SAMPLE_BITS-1:0];
      mixed = (int'(dry) + wet) >>> 1;
      if (ch == 0) res.left = mixed[SAMPLE_BITS-1:0];
      else res.right = mixed[SAMPLE_BITS-1:0];
    end
    wr_pos = wr_pos + 1'b1;
    return res;
  endfunction

  task automatic note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  // result side: compare every accepted beat with the oldest prediction
  always @(posedge clk) begin : check_out
    echo_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (echo_q.size() == 0) begin
        note_fail($sformatf("unexpected beat, left %0d right %0d",
                            out_left_sample, out_right_sample));
      end else begin
        want = echo_q.pop_front();
        if (out_left_sample !== want.left)
          note_fail($sformatf("beat %0d left: expected %0d, got %0d",
                              results_seen, want.left, out_left_sample));
        if (out_right_sample !== want.right)
          note_fail($sformatf("beat %0d right: expected %0d, got %0d",
                              results_seen, want.right, out_right_sample));
      end
      results_seen++;
    end
  end

  // backpressure: random stall bursts while idling is on, ready held high otherwise
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        @(negedge clk);
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  task automatic send_dry(sample_t dry);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_dry_sample <= dry;
    do @(posedge clk); while (!in_ready);
    echo_q.push_back(step_echo(dry));
    items_sent++;
  endtask

  // stop sending and let every outstanding beat come back before touching registers
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(sfd_reg_t idx, logic [DELAY_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LEFT_DELAY:  tap_delay[0] = val[DELAY_W-1:0];
      REG_RIGHT_DELAY: tap_delay[1] = val[DELAY_W-1:0];
      REG_LEFT_GAIN:   tap_gain[0]  = val[GAIN_W-1:0];
      REG_RIGHT_GAIN:  tap_gain[1]  = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic sample_t pick_dry();
    case ($urandom_range(0, 7))
      0:       return ($urandom_range(0, 1) == 1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
      1, 2:    return sample_t'(int'($urandom_range(0, 1023)) - 512);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DELAY_W'(DELAY_MAX);
      2:       return DELAY_W'($urandom_range(1, DELAY_MAX));
      default: return DELAY_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GAIN_W'(GAIN_MAX);
      2:       return GAIN_W'(16384);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // power-on register values, no writes
  task automatic test_reset_defaults();
    settings_used++;
    send_dry(sample_t'(SAMPLE_MAX));
    send_dry(sample_t'(SAMPLE_MIN));
    send_dry(sample_t'(0));
    send_dry(sample_t'(-1));
    send_dry(sample_t'(1));
    send_dry(sample_t'(16'sh5555));
    drain();
  endtask

  // shortest delays with full gain drive the feedback into saturation both ways
  task automatic test_loud_feedback();
    write_reg(REG_LEFT_DELAY, 17'd1);
    write_reg(REG_RIGHT_DELAY, 17'd2);
    write_reg(REG_LEFT_GAIN, DELAY_W'(GAIN_MAX));
    write_reg(REG_RIGHT_GAIN, DELAY_W'(GAIN_MAX));
    settings_used++;
    repeat (4) send_dry(sample_t'(SAMPLE_MAX));
    repeat (4) send_dry(sample_t'(SAMPLE_MIN));
    drain();
  endtask

  // half gain on odd wet values lands exactly between two codes
  task automatic test_rounding_ties();
    write_reg(REG_LEFT_DELAY, 17'd1);
    write_reg(REG_RIGHT_DELAY, 17'd1);
    write_reg(REG_LEFT_GAIN, 17'd16384);
    write_reg(REG_RIGHT_GAIN, 17'd16384);
    settings_used++;
    send_dry(sample_t'(1));
    send_dry(sample_t'(-1));
    send_dry(sample_t'(3));
    send_dry(sample_t'(-3));
    send_dry(sample_t'(0));
    drain();
  endtask

  // zero delay reads the entry at the write position; gain writes carry extra high bits
  task automatic test_zero_and_max_delay();
    write_reg(REG_LEFT_DELAY, 17'd0);
    write_reg(REG_RIGHT_DELAY, DELAY_W'(DELAY_MAX));
    write_reg(REG_LEFT_GAIN, 17'h1FFFF);
    write_reg(REG_RIGHT_GAIN, 17'h18000);
    settings_used++;
    send_dry(sample_t'(SAMPLE_MAX));
    send_dry(sample_t'(SAMPLE_MIN));
    send_dry(sample_t'(12345));
    send_dry(sample_t'(-12345));
    send_dry(sample_t'(1));
    send_dry(sample_t'(-1));
    drain();
  endtask

  // one random register setting, then a run of random samples
  task automatic test_random_echo(int count, bit idling);
    idle_on = idling;
    write_reg(REG_LEFT_DELAY, pick_delay());
    write_reg(REG_RIGHT_DELAY, pick_delay());
    write_reg(REG_LEFT_GAIN, {2'($urandom), pick_gain()});
    write_reg(REG_RIGHT_GAIN, {2'($urandom), pick_gain()});
    settings_used++;
    for (int i = 0; i < count; i++) send_dry(pick_dry());
    drain();
  endtask

  initial begin
    reset_echo_model();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_loud_feedback();
    test_rounding_ties();
    test_zero_and_max_delay();
    for (int p = 0; p < 5; p++) test_random_echo(122, 1'b1);
    test_random_echo(122, 1'b0);

    repeat (10) @(posedge clk);
    if (echo_q.size() != 0) begin
      note_fail($sformatf("%0d predicted beats never arrived", echo_q.size()));
    end
    $display("sent %0d samples, checked %0d stereo beats over %0d register settings",
             items_sent, results_seen, settings_used);
    $display("mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
